FILE: rtl/szp_pkg.sv
// ----------------------------------------------------------------------------
// Size string parser package
// Shared constants, codes, result type and character helpers.
// ----------------------------------------------------------------------------
package szp_pkg;

  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned IDX_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned VAL_W   = 63;
  localparam int unsigned SFX_W   = 6;

  localparam logic [VAL_W-1:0] TOP63 = {VAL_W{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_1     = "1";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";

  localparam logic [4:0] NO_DIGIT = 5'd16;

  localparam logic [SFX_W-1:0] SFX_NONE = 6'd0;
  localparam logic [SFX_W-1:0] SFX_K    = 6'd10;
  localparam logic [SFX_W-1:0] SFX_M    = 6'd20;
  localparam logic [SFX_W-1:0] SFX_G    = 6'd30;
  localparam logic [SFX_W-1:0] SFX_T    = 6'd40;
  localparam logic [SFX_W-1:0] SFX_P    = 6'd50;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_XPEND,
    PH_DIGITS,
    PH_SUFFIX,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    RAD_DEC,
    RAD_OCT,
    RAD_HEX
  } radix_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_RANGE
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic [IDX_W-1:0] stop_offset;
  } szp_res_t;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = 5'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = 5'(c - CH_LA) + 5'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = 5'(c - CH_UA) + 5'd10;
    end
    return d;
  endfunction

  function automatic logic [SFX_W-1:0] suffix_of(input logic [7:0] c);
    logic [SFX_W-1:0] s;
    unique case (c)
      "k", "K": s = SFX_K;
      "m", "M": s = SFX_M;
      "g", "G": s = SFX_G;
      "t", "T": s = SFX_T;
      "p", "P": s = SFX_P;
      default:  s = SFX_NONE;
    endcase
    return s;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

FILE: rtl/szp_if.sv
// ----------------------------------------------------------------------------
// Size string parser channels
// Byte request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface szp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface szp_out_if;
  import szp_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic [1:0]       status;
  logic [IDX_W-1:0] stop_offset;

  modport source (output valid, output value, output status, output stop_offset, input ready);
  modport sink   (input valid, input value, input status, input stop_offset, output ready);
endinterface

FILE: rtl/size_string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// Size string to integer parser
// Streams a NUL-terminated string one byte per request and returns the
// parsed size (strtoll base 0 plus binary k/m/g/t/p suffix) on the NUL.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_bus.ready is high. The result of
// the NUL byte is registered in the output register, or in the skid entry
// while the output register is held. This two-entry output buffer keeps
// bytes flowing while a result waits; ready drops only when both are full.
// Reset (synchronous, rst_n low) returns the parser to the idle state and
// empties the output buffer.
module size_string_to_integer_parser (
  input  logic      clk,
  input  logic      rst_n,
  szp_in_if.sink    in_bus,
  szp_out_if.source out_bus
);
  import szp_pkg::*;

  logic     res_fire;
  szp_res_t res;

  logic     out_valid_r, out_valid_nxt;
  szp_res_t out_data_r, out_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  szp_res_t skid_data_r, skid_data_nxt;
  logic     in_fire;
  logic     out_fire;

  assign in_bus.ready = !skid_valid_r;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_fire     = out_valid_r && out_bus.ready;

  szp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .ch        (in_bus.ch),
    .res_fire  (res_fire),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    // a new result only arrives while the skid entry is empty
    if (res_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_fire) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.value       = out_data_r.value;
  assign out_bus.status      = out_data_r.status;
  assign out_bus.stop_offset = out_data_r.stop_offset;

endmodule

FILE: rtl/szp_parser.sv
// ----------------------------------------------------------------------------
// Size string parser core
// Per-byte parse state machine with shift-add accumulator; forms the result
// from the current state when the NUL byte arrives.
// ----------------------------------------------------------------------------
module szp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_fire,
  input  logic [7:0]        ch,
  output logic              res_fire,
  output szp_pkg::szp_res_t res
);
  import szp_pkg::*;

  phase_t           phase_r, phase_nxt;
  radix_t           radix_r, radix_nxt;
  logic             neg_r, neg_nxt;
  logic [VAL_W-1:0] mag_r, mag_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] dend_r, dend_nxt;
  logic [SFX_W-1:0] sfx_r, sfx_nxt;

  logic [4:0]       dig;
  logic [SFX_W-1:0] sfx_ch;
  logic [4:0]       radix_val;
  logic [VAL_W+3:0] prod;
  logic [VAL_W+3:0] sum;
  logic             acc_ovf;
  logic             oor;
  logic [IDX_W-1:0] idx_inc;
  logic             sfx_ovf;
  logic [VAL_W-1:0] val;
  status_t          st;
  logic [IDX_W-1:0] stop;

  assign dig    = digit_of(ch);
  assign sfx_ch = suffix_of(ch);

  always_comb begin
    unique case (radix_r)
      RAD_OCT: radix_val = 5'd8;
      RAD_HEX: radix_val = 5'd16;
      default: radix_val = 5'd10;
    endcase
  end

  // magnitude * radix + digit, overflow when anything lands above bit 62
  always_comb begin
    unique case (radix_r)
      RAD_OCT: prod = {1'b0, mag_r, 3'b000};
      RAD_HEX: prod = {mag_r, 4'b0000};
      default: prod = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0};
    endcase
  end

  assign sum     = prod + (VAL_W+4)'(dig);
  assign acc_ovf = |sum[VAL_W+3:VAL_W];
  assign oor     = ovf_r || (neg_r && (mag_r != '0));
  assign idx_inc = (idx_r == IDX_W'(MAX_LEN)) ? idx_r : idx_r + 1'b1;
  assign sfx_ovf = (mag_r & ~(TOP63 >> sfx_r)) != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      radix_r <= RAD_DEC;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      dend_r  <= '0;
      sfx_r   <= SFX_NONE;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      dend_r  <= dend_nxt;
      sfx_r   <= sfx_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    dend_nxt  = dend_r;
    sfx_nxt   = sfx_r;
    if (byte_fire) begin
      if (ch == CH_NUL) begin
        // end of string: back to the idle state for the next one
        phase_nxt = PH_WS;
        radix_nxt = RAD_DEC;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
        ovf_nxt   = 1'b0;
        idx_nxt   = '0;
        dend_nxt  = '0;
        sfx_nxt   = SFX_NONE;
      end else begin
        idx_nxt = idx_inc;
        unique case (phase_r)
          PH_WS, PH_SIGN: begin
            priority if (phase_r == PH_WS && is_space(ch)) begin
              phase_nxt = PH_WS;
            end else if (phase_r == PH_WS && (ch == CH_PLUS || ch == CH_MINUS)) begin
              neg_nxt   = (ch == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else if (ch == CH_0) begin
              radix_nxt = RAD_OCT;
              phase_nxt = PH_ZERO;
            end else if (ch >= CH_1 && ch <= CH_9) begin
              // magnitude is zero here, so the first digit cannot overflow
              radix_nxt = RAD_DEC;
              mag_nxt   = sum[VAL_W-1:0];
              phase_nxt = PH_DIGITS;
            end else begin
              mag_nxt  = '0;
              neg_nxt  = 1'b0;
              dend_nxt = '0;
              if (idx_r == '0 && sfx_ch != SFX_NONE) begin
                // a bare suffix letter reads as zero with a suffix
                sfx_nxt   = sfx_ch;
                dend_nxt  = IDX_W'(1);
                phase_nxt = PH_SUFFIX;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
          PH_ZERO: begin
            priority if (ch == CH_LX || ch == CH_UX) begin
              dend_nxt  = idx_r;
              phase_nxt = PH_XPEND;
            end else if (dig < 5'd8) begin
              mag_nxt   = sum[VAL_W-1:0];
              phase_nxt = PH_DIGITS;
            end else begin
              dend_nxt = idx_r;
              if (sfx_ch != SFX_NONE) begin
                sfx_nxt   = sfx_ch;
                dend_nxt  = idx_inc;
                phase_nxt = PH_SUFFIX;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
          PH_XPEND: begin
            if (dig < NO_DIGIT) begin
              radix_nxt = RAD_HEX;
              mag_nxt   = {{(VAL_W-5){1'b0}}, dig};
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_DIGITS: begin
            if (dig < radix_val) begin
              // once overflowed, hold the magnitude and keep consuming digits
              if (!ovf_r) begin
                if (acc_ovf) begin
                  ovf_nxt = 1'b1;
                end else begin
                  mag_nxt = sum[VAL_W-1:0];
                end
              end
            end else begin
              dend_nxt = idx_r;
              priority if (oor) begin
                phase_nxt = PH_SKIP;
              end else if (sfx_ch != SFX_NONE) begin
                sfx_nxt   = sfx_ch;
                dend_nxt  = idx_inc;
                phase_nxt = PH_SUFFIX;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
          PH_SUFFIX: begin
            phase_nxt = PH_SKIP;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    val  = '0;
    st   = ST_OK;
    stop = '0;
    unique case (phase_r)
      PH_WS, PH_SIGN: begin
        st = (idx_r == '0) ? ST_OK : ST_INVALID;
      end
      PH_ZERO: begin
        stop = idx_r;
      end
      PH_XPEND: begin
        st   = ST_INVALID;
        stop = dend_r;
      end
      PH_DIGITS: begin
        stop = idx_r;
        if (oor) begin
          st = ST_RANGE;
        end else begin
          val = mag_r;
        end
      end
      PH_SUFFIX: begin
        stop = dend_r;
        if (sfx_ovf) begin
          st = ST_RANGE;
        end else begin
          val = mag_r << sfx_r;
        end
      end
      default: begin
        st   = oor ? ST_RANGE : ST_INVALID;
        stop = dend_r;
      end
    endcase
  end

  assign res_fire        = byte_fire && (ch == CH_NUL);
  assign res.value       = (st == ST_OK) ? val : '0;
  assign res.status      = st;
  assign res.stop_offset = stop;

endmodule

FILE: bench/tb_size_string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// Size string parser testbench
// Streams NUL-terminated strings into the parser one byte per request and
// compares every returned size, status and stop offset against a cycle-free
// parse of the same bytes held in a scoreboard. Both sides idle at random,
// and the result side holds off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
import szp_pkg::*;

typedef logic [7:0] text_t[$];

class size_parse_board;
  localparam logic [63:0] MAX_POS = {1'b0, TOP63};

  phase_t           stage;
  radix_t           base;
  bit               neg;
  logic [63:0]      mag;
  bit               ovf;
  bit               any_digit;
  int unsigned      pos;
  int unsigned      num_end;
  logic [SFX_W-1:0] shift;
  bit               junk;

  szp_res_t sizes_due[$];
  int       errors;
  int       sizes_checked;

  function new();
    errors        = 0;
    sizes_checked = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    stage     = PH_WS;
    base      = RAD_DEC;
    neg       = 1'b0;
    mag       = '0;
    ovf       = 1'b0;
    any_digit = 1'b0;
    pos       = 0;
    num_end   = 0;
    shift     = SFX_NONE;
    junk      = 1'b0;
  endfunction

  function int unsigned clamp_len(int unsigned v);
    return (v > MAX_LEN) ? MAX_LEN : v;
  endfunction

  function logic [4:0] digit_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return NO_DIGIT;
  endfunction

  // Non-letters map to no suffix; letters are folded to lower case before the match.
  function logic [SFX_W-1:0] shift_for(logic [7:0] c);
    if (!((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) return SFX_NONE;
    case (c | 8'h20)
      "k": return SFX_K;
      "m": return SFX_M;
      "g": return SFX_G;
      "t": return SFX_T;
      "p": return SFX_P;
      default: return SFX_NONE;
    endcase
  endfunction

  function bit blank(logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function logic [63:0] radix_num();
    if (base == RAD_OCT) return 64'd8;
    if (base == RAD_HEX) return 64'd16;
    return 64'd10;
  endfunction

  function bit beyond();
    return ovf || (neg && mag != 0);
  endfunction

  function void add_digit(logic [4:0] d);
    logic [63:0] r;
    r = radix_num();
    any_digit = 1'b1;
    if (ovf) return;
    if (mag > (MAX_POS - 64'(d)) / r) begin
      ovf = 1'b1;
    end else begin
      mag = mag * r + 64'(d);
    end
  endfunction

  function void close_digits(logic [7:0] c);
    logic [SFX_W-1:0] s;
    s = shift_for(c);
    num_end = pos;
    if (beyond()) begin
      stage = PH_SKIP;
    end else if (s != SFX_NONE) begin
      shift   = s;
      num_end = clamp_len(pos + 1);
      stage   = PH_SUFFIX;
    end else begin
      junk  = 1'b1;
      stage = PH_SKIP;
    end
  endfunction

  function void no_number(logic [7:0] c);
    logic [SFX_W-1:0] s;
    s = shift_for(c);
    mag     = '0;
    neg     = 1'b0;
    num_end = 0;
    if (pos == 0 && s != SFX_NONE) begin
      shift   = s;
      num_end = 1;
      stage   = PH_SUFFIX;
    end else begin
      junk  = 1'b1;
      stage = PH_SKIP;
    end
  endfunction

  // Advance the parse by one accepted byte; on NUL queue the expected size.
  function void take_byte(logic [7:0] c);
    logic [4:0]  d;
    logic [63:0] val;
    status_t     st;
    int unsigned stop;
    szp_res_t    res;
    d    = digit_val(c);
    val  = '0;
    st   = ST_OK;
    stop = 0;
    if (c == CH_NUL) begin
      case (stage)
        PH_WS, PH_SIGN: begin
          st = (pos == 0) ? ST_OK : ST_INVALID;
        end
        PH_ZERO: stop = pos;
        PH_XPEND: begin
          st   = ST_INVALID;
          stop = num_end;
        end
        PH_DIGITS: begin
          stop = pos;
          if (beyond()) st = ST_RANGE;
          else val = mag;
        end
        PH_SUFFIX: begin
          stop = num_end;
          if (shift != SFX_NONE && mag > (MAX_POS >> shift)) st = ST_RANGE;
          else val = mag << shift;
        end
        default: begin
          st   = beyond() ? ST_RANGE : ST_INVALID;
          stop = num_end;
        end
      endcase
      res.value       = (st == ST_OK) ? val[VAL_W-1:0] : '0;
      res.status      = st;
      res.stop_offset = IDX_W'(clamp_len(stop));
      sizes_due.push_back(res);
      clear_parse();
      return;
    end
    case (stage)
      PH_WS, PH_SIGN: begin
        if (stage == PH_WS && blank(c)) begin
        end else if (stage == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
          neg   = (c == CH_MINUS);
          stage = PH_SIGN;
        end else if (c == CH_0) begin
          any_digit = 1'b1;
          base      = RAD_OCT;
          stage     = PH_ZERO;
        end else if (c >= CH_1 && c <= CH_9) begin
          base = RAD_DEC;
          add_digit(d);
          stage = PH_DIGITS;
        end else begin
          no_number(c);
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          num_end = pos;
          stage   = PH_XPEND;
        end else if (d < 5'd8) begin
          add_digit(d);
          stage = PH_DIGITS;
        end else begin
          close_digits(c);
        end
      end
      PH_XPEND: begin
        if (d < 5'd16) begin
          base = RAD_HEX;
          add_digit(d);
          stage = PH_DIGITS;
        end else begin
          junk  = 1'b1;
          stage = PH_SKIP;
        end
      end
      PH_DIGITS: begin
        if (64'(d) < radix_num()) add_digit(d);
        else close_digits(c);
      end
      PH_SUFFIX: begin
        junk  = 1'b1;
        stage = PH_SKIP;
      end
      default: begin
      end
    endcase
    pos = clamp_len(pos + 1);
  endfunction

  function void check_size(logic [VAL_W-1:0] value, logic [1:0] status,
                           logic [IDX_W-1:0] stop_offset);
    szp_res_t want;
    if (sizes_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result value=%0d status=%0d stop=%0d",
               $time, value, status, stop_offset);
      return;
    end
    want = sizes_due.pop_front();
    sizes_checked++;
    if (value !== want.value) begin
      errors++;
      $display("%0t: value mismatch: expected %0d, actual %0d", $time, want.value, value);
    end
    if (status !== 2'(want.status)) begin
      errors++;
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, 2'(want.status), status);
    end
    if (stop_offset !== want.stop_offset) begin
      errors++;
      $display("%0t: stop offset mismatch: expected %0d, actual %0d",
               $time, want.stop_offset, stop_offset);
    end
  endfunction

  function int pending();
    return sizes_due.size();
  endfunction
endclass

module tb_size_string_to_integer_parser;
  localparam int RANDOM_BYTES = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst_n;

  szp_in_if  in_bus();
  szp_out_if out_bus();

  size_string_to_integer_parser uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  size_parse_board sb = new();

  bit gaps_on;
  bit hold_req;
  int cycles;
  int strings_sent;
  int bytes_sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one byte and hold it until the parser takes it.
  task automatic send_byte(input logic [7:0] c);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.ch    = c;
    do @(posedge clk); while (!in_bus.ready);
    sb.take_byte(c);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_byte(t[i]);
    send_byte(CH_NUL);
    strings_sent++;
  endtask

  task automatic send_str(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  function automatic logic [7:0] pick(input string from);
    return from[$urandom_range(0, from.len() - 1)];
  endfunction

  function automatic logic [7:0] any_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  // Optional whitespace and sign, hex or octal prefix, digits, optional suffix and tail.
  function automatic text_t make_number();
    text_t t;
    int    n;
    int    kind;
    repeat ($urandom_range(0, 3)) t.push_back(pick(" \t\n\013\014\r"));
    if ($urandom_range(0, 2) == 0) t.push_back(pick("+-"));
    kind = $urandom_range(0, 3);
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 8);
    if (kind == 0) begin
      t.push_back("0");
      t.push_back(pick("xX"));
      if ($urandom_range(0, 3) == 0) t.push_back(pick("78"));
      repeat (n) t.push_back(pick("0123456789abcdefABCDEF"));
    end else if (kind == 1) begin
      t.push_back("0");
      repeat (n - 1) t.push_back(pick("01234567"));
    end else begin
      t.push_back(pick("123456789"));
      repeat (n - 1) t.push_back(pick("0123456789"));
    end
    if ($urandom_range(0, 1) == 0) t.push_back(pick("kKmMgGtTpP"));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) t.push_back(any_nonzero());
    end
    return t;
  endfunction

  function automatic text_t make_noise();
    text_t t;
    repeat ($urandom_range(0, 8)) t.push_back(any_nonzero());
    return t;
  endfunction

  // Result side: random back-pressure bursts plus one long hold on request.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req      = 1'b0;
        out_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (rst_n && gaps_on && $urandom_range(0, 4) == 0) begin
        out_bus.ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_bus.ready = rst_n;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_size(out_bus.value, out_bus.status, out_bus.stop_offset);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycles, sb.pending());
    $display("FAIL");
    $finish;
  end

  initial begin
    text_t t;
    int    rnd_bytes;
    rst_n        = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.ch    = CH_NUL;
    gaps_on      = 1'b0;
    hold_req     = 1'b0;
    strings_sent = 0;
    bytes_sent   = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed corners.
    send_str("");
    send_str("0");
    send_str("  +12k");
    send_str("-0");
    send_str("-5");
    send_str("0x");
    send_str("0xg");
    send_str("0x1F");
    send_str("0777");
    send_str("09");
    send_str("k");
    send_str("Z");
    send_str("-k");
    send_str("+");
    send_str("12kb");
    send_str("12 ");
    send_str("5\377");
    send_str("\t\n\013\014\r 7");
    send_str("9223372036854775807");
    send_str("9223372036854775808");
    send_str("99999999999999999999zz");
    send_str("8191p");
    send_str("8192P");
    send_str("0x7fffffffffffffffK");
    send_str("0X10M");
    send_str("1g");
    send_str("3T");
    send_str("1m");

    // Fill the block: hold the result side while short strings keep coming.
    gaps_on  = 1'b1;
    hold_req = 1'b1;
    repeat (20) send_str("7");

    rnd_bytes = bytes_sent;
    while (bytes_sent - rnd_bytes < RANDOM_BYTES) begin
      // Keep a quiet stretch mid-run and a quiet tail.
      gaps_on = ((strings_sent / 40) % 4 != 2) &&
                (bytes_sent - rnd_bytes < RANDOM_BYTES * 4 / 5);
      case ($urandom_range(0, 9))
        0, 1: send_text(make_noise());
        2: begin
          t = make_number();
          t[$urandom_range(0, t.size() - 1)] = any_nonzero();
          send_text(t);
        end
        default: send_text(make_number());
      endcase
    end
    gaps_on      = 1'b0;
    in_bus.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d strings in %0d bytes; %0d results checked.",
             strings_sent, bytes_sent, sb.sizes_checked);
    $display("Covered signs, octal/hex/decimal, suffixes, overflow and junk bytes.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/szp_pkg.sv
rtl/szp_if.sv
rtl/szp_parser.sv
rtl/size_string_to_integer_parser.sv
bench/tb_size_string_to_integer_parser.sv
